/* rtl/core/sbq_pkg.sv */
// Shared types, constants and helpers for the stereo biquad cascade equaliser.
`default_nettype none
package sbq_pkg;
    localparam int MAX_SECTIONS_DEF   = 8;
    localparam int CHANNEL_COUNT_DEF  = 2;
    localparam int COEF_FRAC_BITS_DEF = 28;
    localparam int SLOTS = 5;
    localparam int ACC_W = 48;
    localparam int PROD_W = 81;
    // wide enough for a shifted product plus two more terms at the smallest fraction width
    localparam int SUM_W = 64;

    typedef enum logic [1:0] {
        REQ_FRAME = 2'd0,
        REQ_COEF  = 2'd1,
        REQ_PEAK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_SECTIONS = 2'd0,
        CFG_GAIN     = 2'd1,
        CFG_ENABLE   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SLOT_B0 = 3'd0,
        SLOT_B1 = 3'd1,
        SLOT_B2 = 3'd2,
        SLOT_A1 = 3'd3,
        SLOT_A2 = 3'd4
    } slot_t;

    // lane sequencer phases
    typedef enum logic [2:0] {
        LS_IDLE,
        LS_B0,
        LS_B1,
        LS_A1,
        LS_B2,
        LS_A2,
        LS_DONE
    } lane_st_t;

    typedef struct packed {
        logic start;
        logic clear_all;
    } lane_ctl_t;

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        begin
            hi = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
            lo = -hi - SUM_W'(1);
            if (v > hi)
                sat48 = hi[ACC_W-1:0];
            else if (v < lo)
                sat48 = lo[ACC_W-1:0];
            else
                sat48 = v[ACC_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/core/sbq_lane.sv */
// One channel lane: shared multiplier stepping through the biquad sections.
`default_nettype none
module sbq_lane #(
    parameter int MAX_SECTIONS   = sbq_pkg::MAX_SECTIONS_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF,
    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
    localparam int CW = $clog2(MAX_SECTIONS * sbq_pkg::SLOTS)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire sbq_pkg::lane_ctl_t             ctl,
    input  wire logic [SW:0]                    n_sections,
    input  wire logic [SW:0]                    clr_from,
    input  wire logic                           clr_en,
    input  wire logic signed [sbq_pkg::ACC_W-1:0] x_in,
    output logic [CW-1:0]                       coef_addr,
    input  wire logic signed [31:0]             coef,
    output logic                                done,
    output logic signed [sbq_pkg::ACC_W-1:0]    y_out
);
    localparam int AW = sbq_pkg::ACC_W;
    localparam int PW = sbq_pkg::PROD_W;
    localparam int SUMW = sbq_pkg::SUM_W;

    logic signed [AW-1:0] d1_mem [MAX_SECTIONS];
    logic signed [AW-1:0] d2_mem [MAX_SECTIONS];

    sbq_pkg::lane_st_t st_reg, st_next;
    logic [SW-1:0] sec_reg, sec_next;
    logic signed [AW-1:0] x_reg, x_next;
    logic signed [AW-1:0] y_reg, y_next;
    logic signed [SUMW-1:0] acc_reg, acc_next;
    logic ph_reg, ph_next;
    logic signed [48:0] lo_reg, lo_next;
    logic signed [48:0] plo;
    logic signed [63:0] phi;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] mop;
    logic signed [SUMW-1:0] term;
    logic last_sec;
    logic compute;
    logic [2:0] slot;

    assign last_sec = ({1'b0, sec_reg} == n_sections - (SW+1)'(1));
    assign compute  = st_reg inside {sbq_pkg::LS_B0, sbq_pkg::LS_B1, sbq_pkg::LS_A1,
                                     sbq_pkg::LS_B2, sbq_pkg::LS_A2};

    // address the step that starts at the next edge; the read is registered outside
    always_comb
    begin
        slot = 3'(sbq_pkg::SLOT_B0);
        case (st_next)
            sbq_pkg::LS_B1: slot = 3'(sbq_pkg::SLOT_B1);
            sbq_pkg::LS_A1: slot = 3'(sbq_pkg::SLOT_A1);
            sbq_pkg::LS_B2: slot = 3'(sbq_pkg::SLOT_B2);
            sbq_pkg::LS_A2: slot = 3'(sbq_pkg::SLOT_A2);
            default:        slot = 3'(sbq_pkg::SLOT_B0);
        endcase
    end
    assign coef_addr = CW'(sec_next * sbq_pkg::SLOTS) + CW'(slot);

    // each step is split in two halves: low 16 operand bits first, then the high 32 bits;
    // floor(c*v / 2^F) is an arithmetic shift of the recombined exact product
    assign mop  = (st_reg == sbq_pkg::LS_A1 || st_reg == sbq_pkg::LS_A2) ? y_reg : x_reg;
    assign plo  = coef * $signed({1'b0, mop[15:0]});
    assign phi  = coef * $signed(mop[AW-1:16]);
    assign prod = (PW'(phi) <<< 16) + PW'(lo_reg);
    assign term = SUMW'(prod >>> COEF_FRAC_BITS);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            sbq_pkg::LS_IDLE:
                if (ctl.start)
                    st_next = (n_sections == '0) ? sbq_pkg::LS_DONE : sbq_pkg::LS_B0;
            sbq_pkg::LS_B0: if (ph_reg) st_next = sbq_pkg::LS_B1;
            sbq_pkg::LS_B1: if (ph_reg) st_next = sbq_pkg::LS_A1;
            sbq_pkg::LS_A1: if (ph_reg) st_next = sbq_pkg::LS_B2;
            sbq_pkg::LS_B2: if (ph_reg) st_next = sbq_pkg::LS_A2;
            sbq_pkg::LS_A2:
                if (ph_reg)
                    st_next = last_sec ? sbq_pkg::LS_DONE : sbq_pkg::LS_B0;
            sbq_pkg::LS_DONE: st_next = sbq_pkg::LS_IDLE;
            default: st_next = sbq_pkg::LS_IDLE;
        endcase
    end

    always_comb
    begin
        sec_next = sec_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        ph_next  = 1'b0;
        lo_next  = lo_reg;
        if (compute)
        begin
            ph_next = !ph_reg;
            if (!ph_reg)
                lo_next = plo;
        end
        case (st_reg)
            sbq_pkg::LS_IDLE:
                if (ctl.start)
                begin
                    sec_next = '0;
                    x_next   = x_in;
                end
            sbq_pkg::LS_B0:
                if (ph_reg)
                    y_next = sbq_pkg::sat48(term + SUMW'(d1_mem[sec_reg]));
            sbq_pkg::LS_B1: if (ph_reg) acc_next = term;
            sbq_pkg::LS_A1: if (ph_reg) acc_next = acc_reg - term;
            sbq_pkg::LS_B2: if (ph_reg) acc_next = term;
            sbq_pkg::LS_A2:
                if (ph_reg)
                begin
                    x_next   = y_reg;
                    sec_next = last_sec ? sec_reg : sec_reg + SW'(1);
                end
            default: ;
        endcase
    end

    assign done  = (st_reg == sbq_pkg::LS_DONE);
    assign y_out = x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= sbq_pkg::LS_IDLE;
            ph_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg <= sec_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
    end

    // delay state: one d1/d2 pair per section, all reset and cleared together, or cleared from clr_from up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                d1_mem[i] <= '0;
                d2_mem[i] <= '0;
            end
        end
        else if (ctl.clear_all)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                d1_mem[i] <= '0;
                d2_mem[i] <= '0;
            end
        end
        else if (clr_en)
        begin
            for (int i = 0; i < MAX_SECTIONS; i++)
                if ((SW+1)'(i) >= clr_from)
                begin
                    d1_mem[i] <= '0;
                    d2_mem[i] <= '0;
                end
        end
        else if (st_reg == sbq_pkg::LS_A1 && ph_reg)
            d1_mem[sec_reg] <= sbq_pkg::sat48(acc_reg - term
                               + SUMW'(d2_mem[sec_reg]));
        else if (st_reg == sbq_pkg::LS_A2 && ph_reg)
            d2_mem[sec_reg] <= sbq_pkg::sat48(acc_reg - term);
    end
endmodule
`default_nettype wire

/* rtl/core/sbq_merge.sv */
// Merge stage: round and clamp each lane result and take the frame peak.
`default_nettype none
module sbq_merge #(
    parameter int CHANNEL_COUNT = sbq_pkg::CHANNEL_COUNT_DEF
) (
    input  wire logic signed [sbq_pkg::ACC_W-1:0] y [CHANNEL_COUNT],
    output logic signed [15:0]                    pcm [CHANNEL_COUNT],
    output logic [23:0]                           frame_peak
);
    localparam int AW = sbq_pkg::ACC_W;
    logic [AW-1:0] mag [CHANNEL_COUNT];
    logic [AW-13:0] whole [CHANNEL_COUNT];
    logic [AW-12:0] rnd [CHANNEL_COUNT];

    always_comb
    begin
        frame_peak = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            mag[c]   = y[c][AW-1] ? AW'(-y[c]) : AW'(y[c]);
            whole[c] = mag[c][AW-1:12];
            rnd[c]   = (AW-11)'(whole[c]) + (AW-11)'(mag[c][11]);
            if (y[c][AW-1])
                pcm[c] = (rnd[c] > (AW-11)'(32768)) ? 16'sh8000 : 16'(-rnd[c]);
            else
                pcm[c] = (rnd[c] > (AW-11)'(32767)) ? 16'sh7FFF : 16'(rnd[c]);
            if (whole[c] > (AW-12)'(24'hFFFFFF))
            begin
                if (frame_peak < 24'hFFFFFF)
                    frame_peak = 24'hFFFFFF;
            end
            else if (24'(whole[c]) > frame_peak)
                frame_peak = 24'(whole[c]);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/stereo_biquad_cascade_eq_unit.sv */
// Top level: request decode, configuration, coefficient memory, lanes and output stage.
`default_nettype none
// One request is taken at a time. Each channel lane steps through b0, b1, a1, b2, a2 of
// every section in use, each step in two halves because the 32x48 product is split into a
// 32x17 and a 32x32 multiply, and the channels run side by side. A filtered frame keeps
// the unit busy until the lanes are done, and no new request is taken meanwhile. Bypassed
// frames and other requests give their result straight from the transfer into the output
// register and can follow back to back while the output drains. The result waits in an
// output register, and a new request is taken as soon as the held result is free or
// leaving. Coefficients not yet written read as anything.
module stereo_biquad_cascade_eq_unit #(
    parameter int MAX_SECTIONS   = sbq_pkg::MAX_SECTIONS_DEF,
    parameter int CHANNEL_COUNT  = sbq_pkg::CHANNEL_COUNT_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: left_sample, right_sample, coef_section, coef_slot, coef_value, zero pad
    input  wire logic [71:0] s_tdata,
    // tuser: req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: left_out, right_out, peak_level
    output logic [55:0]      m_tdata
);
    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int NC = MAX_SECTIONS * sbq_pkg::SLOTS;
    localparam int CW = $clog2(NC);
    localparam int AW = sbq_pkg::ACC_W;

    logic [3:0]  nsec_reg;
    logic [15:0] gain_reg;
    logic        en_reg;
    logic [23:0] peak_reg, peak_next;
    logic        busy_reg;
    logic        ovalid_reg;
    logic [55:0] odata_reg;

    logic [SW:0] eff_sec, new_eff;
    logic        take;
    logic [1:0]  rq;
    logic signed [15:0] in_s [2];
    logic        bypass;
    sbq_pkg::lane_ctl_t ctl;
    logic        clr_en;

    logic signed [31:0] coef_mem [NC];
    logic [CW-1:0] caddr [CHANNEL_COUNT];
    logic signed [31:0] cval_reg [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] ldone;
    logic signed [AW-1:0] ly [CHANNEL_COUNT];
    logic signed [AW-1:0] lx [CHANNEL_COUNT];
    logic signed [15:0] pcm [CHANNEL_COUNT];
    logic [23:0] fpeak;
    logic [CW-1:0] waddr;

    assign rq    = s_tuser;
    assign in_s[0] = s_tdata[15:0];
    assign in_s[1] = s_tdata[31:16];
    assign eff_sec = ({1'b0, nsec_reg} > 5'(MAX_SECTIONS)) ? (SW+1)'(MAX_SECTIONS)
                   : (SW+1)'(nsec_reg);
    assign new_eff = ({1'b0, cfg_data[3:0]} > 5'(MAX_SECTIONS)) ? (SW+1)'(MAX_SECTIONS)
                   : (SW+1)'(cfg_data[3:0]);
    assign bypass = !en_reg || (eff_sec == '0 && gain_reg == 16'd4096);

    assign s_tready = !busy_reg && (!ovalid_reg || m_tready);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    assign ctl.start = take && rq == 2'(sbq_pkg::REQ_FRAME) && !bypass;
    assign ctl.clear_all = (take && rq == 2'(sbq_pkg::REQ_CLEAR))
                        || (cfg_we && cfg_index == 2'(sbq_pkg::CFG_ENABLE) && cfg_data[0] && !en_reg);
    assign clr_en = cfg_we && cfg_index == 2'(sbq_pkg::CFG_SECTIONS) && new_eff > eff_sec;

    assign waddr = CW'(s_tdata[34:32] * sbq_pkg::SLOTS) + CW'(s_tdata[37:35]);

    always_ff @(posedge clk)
    begin
        if (take && rq == 2'(sbq_pkg::REQ_COEF) && s_tdata[37:35] < 3'(sbq_pkg::SLOTS)
            && 32'(s_tdata[34:32]) < 32'(MAX_SECTIONS))
            coef_mem[waddr] <= s_tdata[69:38];
    end

    for (genvar c = 0; c < CHANNEL_COUNT; c++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            cval_reg[c] <= coef_mem[caddr[c]];
        end
        assign lx[c] = AW'(in_s[c]) * AW'(signed'({1'b0, gain_reg}));
        sbq_lane #(
            .MAX_SECTIONS  (MAX_SECTIONS),
            .COEF_FRAC_BITS(COEF_FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .n_sections(eff_sec),
            .clr_from  (eff_sec),
            .clr_en    (clr_en),
            .x_in      (lx[c]),
            .coef_addr (caddr[c]),
            .coef      (cval_reg[c]),
            .done      (ldone[c]),
            .y_out     (ly[c])
        );
    end

    sbq_merge #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_merge (
        .y         (ly),
        .pcm       (pcm),
        .frame_peak(fpeak)
    );

    always_comb
    begin
        peak_next = peak_reg;
        if (take && rq == 2'(sbq_pkg::REQ_PEAK))
            peak_next = '0;
        else if (ldone[0] && fpeak > peak_reg)
            peak_next = fpeak;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsec_reg   <= '0;
            gain_reg   <= 16'd4096;
            en_reg     <= 1'b1;
            peak_reg   <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    2'(sbq_pkg::CFG_SECTIONS): nsec_reg <= cfg_data[3:0];
                    2'(sbq_pkg::CFG_GAIN):     gain_reg <= cfg_data;
                    2'(sbq_pkg::CFG_ENABLE):   en_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            peak_reg <= peak_next;
            if (ctl.start)
                busy_reg <= 1'b1;
            else if (ldone[0])
                busy_reg <= 1'b0;
            if (ldone[0] || (take && !ctl.start))
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (rq == 2'(sbq_pkg::REQ_FRAME))
                odata_reg <= {24'd0, (CHANNEL_COUNT > 1) ? s_tdata[31:16] : 16'd0,
                              s_tdata[15:0]};
            else if (rq == 2'(sbq_pkg::REQ_PEAK))
                odata_reg <= {peak_reg, 32'd0};
            else
                odata_reg <= '0;
        end
        else if (ldone[0])
            odata_reg <= {24'd0, (CHANNEL_COUNT > 1) ? pcm[CHANNEL_COUNT-1] : 16'sd0, pcm[0]};
    end
endmodule
`default_nettype wire
